>>> rtl/pcc_pkg.sv
// Package for the palette colour cycler: command codes, control structs.
// No dependencies.
`timescale 1ns / 1ps
package pcc_pkg;

  typedef enum logic [2:0] {
    MODE_LOAD    = 3'd0,
    MODE_ROTATE  = 3'd1,
    MODE_BLEND   = 3'd2,
    MODE_SHIFT_R = 3'd3,
    MODE_SHIFT_L = 3'd4,
    MODE_LOOKUP  = 3'd5,
    MODE_NOP6    = 3'd6,
    MODE_NOP7    = 3'd7
  } mode_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the input item
    logic load;       // write colour_in into both palettes
    logic lookup;     // read working palette for a result
    logic frame_step; // one restoring step of cycle mod len
    logic rd_src_a;   // read source at position a
    logic rd_src_b;   // read source at position b
    logic rd_work;    // read working at the shift position
    logic wr_work;    // write working at the current j
    logic hold_first; // keep the first shifted entry
    logic adv;        // advance j and the positions
    logic wr_tail;    // write the held entry at the shift end
  } ctrl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic range_ok;   // the latched range is valid
    logic last;       // j is at its last element
  } stat_t;

  localparam int unsigned FRAME_STEPS = 16;

endpackage

>>> rtl/pcc_datapath.sv
// Datapath of the palette colour cycler: both palette memories, frame
// reduction, position counters, blend unit. Depends on pcc_pkg.
`timescale 1ns / 1ps
module pcc_datapath #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pcc_pkg::ctrl_t ctrl_i,
  output pcc_pkg::stat_t stat_o,
  input  logic [2:0]    mode_i,
  input  logic [7:0]    entry_index_i,
  input  logic [31:0]   colour_in_i,
  input  logic [7:0]    range_low_i,
  input  logic [7:0]    range_high_i,
  input  logic [15:0]   cycle_count_i,
  input  logic [7:0]    blend_fraction_i,
  output logic [2:0]    mode_o,
  output logic          valid_o,
  output logic [31:0]   colour_out_o
);
  localparam int unsigned AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  logic [31:0] src_mem [PALETTE_ENTRIES];
  logic [31:0] work_mem [PALETTE_ENTRIES];

  logic [2:0]  mode_q;
  logic [7:0]  idx_q, low_q, high_q, frac_q;
  logic [31:0] col_q;
  logic [8:0]  len_q;
  logic [8:0]  rem_q;   // restoring remainder, always below len
  logic [15:0] quo_q;   // cycle bits still to enter
  logic [4:0]  fstep_q;
  logic [7:0]  j_q;     // offset inside the range
  logic [8:0]  pa_q, pb_q; // offsets (j+frame) mod len, +1 mod len
  logic [31:0] rda_q, rdb_q, rdw_q, held_q;
  logic        valid_q;
  logic [31:0] res_q;

  // one step of cycle mod len per cycle while frame_step is high
  logic [9:0] rem_sh;
  logic [8:0] rem_next;
  assign rem_sh   = {rem_q, quo_q[15]};
  assign rem_next = (rem_sh >= {1'b0, len_q}) ? 9'(rem_sh - {1'b0, len_q}) : rem_sh[8:0];

  function automatic logic [8:0] wrap(input logic [8:0] v, input logic [8:0] l);
    wrap = (v >= l) ? v - l : v;
  endfunction

  logic [AW-1:0] addr_a, addr_b, addr_j, addr_sh;
  assign addr_a  = AW'({1'b0, low_q} + pa_q);
  assign addr_b  = AW'({1'b0, low_q} + pb_q);
  assign addr_j  = AW'({1'b0, low_q} + {1'b0, j_q});
  // shift right reads j-1 going down from high; shift left reads j+1
  logic [7:0] j_sh;
  assign j_sh   = (mode_q == pcc_pkg::MODE_SHIFT_R) ? high_q - j_q - 8'd1 : low_q + j_q + 8'd1;
  logic [7:0] j_wr;
  assign j_wr   = (mode_q == pcc_pkg::MODE_SHIFT_R) ? high_q - j_q : low_q + j_q;
  assign addr_sh = AW'(j_sh);

  // per-channel blend: floor(a + (b-a)*f/256)
  logic [31:0] blend;
  always_comb begin
    logic signed [17:0] num;
    for (int c = 0; c < 4; c++) begin
      num = $signed({10'd0, rda_q[c*8 +: 8]}) * 18'sd256
          + ($signed({10'd0, rdb_q[c*8 +: 8]}) - $signed({10'd0, rda_q[c*8 +: 8]}))
          * $signed({10'd0, frac_q});
      blend[c*8 +: 8] = num[15:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.latch) begin
      mode_q  <= mode_i;
      idx_q   <= entry_index_i;
      col_q   <= colour_in_i;
      low_q   <= range_low_i;
      high_q  <= range_high_i;
      frac_q  <= blend_fraction_i;
      len_q   <= {1'b0, range_high_i} - {1'b0, range_low_i} + 9'd1;
      rem_q   <= '0;
      quo_q   <= cycle_count_i;
      j_q     <= '0;
    end
    if (ctrl_i.frame_step) begin
      rem_q <= rem_next;
      quo_q <= {quo_q[14:0], 1'b0};
      if (fstep_q == 5'(pcc_pkg::FRAME_STEPS - 1)) begin
        pa_q <= rem_next;
        pb_q <= wrap(rem_next + 9'd1, len_q);
      end
    end
    if (ctrl_i.load && ({1'b0, idx_q} < 9'(PALETTE_ENTRIES))) begin
      src_mem[AW'(idx_q)]  <= col_q;
      work_mem[AW'(idx_q)] <= col_q;
    end
    if (ctrl_i.rd_src_a) rda_q <= src_mem[addr_a];
    if (ctrl_i.rd_src_b) rdb_q <= src_mem[addr_b];
    if (ctrl_i.rd_work)  rdw_q <= work_mem[addr_sh];
    if (ctrl_i.hold_first)
      held_q <= work_mem[AW'((mode_q == pcc_pkg::MODE_SHIFT_R) ? high_q : low_q)];
    if (ctrl_i.wr_work) begin
      if (mode_q == pcc_pkg::MODE_ROTATE)     work_mem[addr_j] <= rda_q;
      else if (mode_q == pcc_pkg::MODE_BLEND) work_mem[addr_j] <= blend;
      else                                    work_mem[AW'(j_wr)] <= rdw_q;
    end
    if (ctrl_i.wr_tail)
      work_mem[AW'((mode_q == pcc_pkg::MODE_SHIFT_R) ? low_q : high_q)] <= held_q;
    if (ctrl_i.adv) begin
      j_q  <= j_q + 8'd1;
      pa_q <= wrap(pa_q + 9'd1, len_q);
      pb_q <= wrap(pb_q + 9'd1, len_q);
    end
    if (ctrl_i.lookup)
      res_q <= ({1'b0, idx_q} < 9'(PALETTE_ENTRIES)) ? work_mem[AW'(idx_q)] : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      fstep_q <= '0;
    end else begin
      valid_q <= ctrl_i.lookup;
      if (ctrl_i.latch)           fstep_q <= '0;
      else if (ctrl_i.frame_step) fstep_q <= fstep_q + 5'd1;
    end
  end

  logic [7:0] last_j;
  assign last_j = high_q - low_q - 8'd1;
  always_comb begin
    stat_o.range_ok = (low_q < high_q) && ({1'b0, high_q} < 9'(PALETTE_ENTRIES));
    stat_o.last = (mode_q == pcc_pkg::MODE_ROTATE || mode_q == pcc_pkg::MODE_BLEND)
                ? (j_q == high_q - low_q) : (j_q == last_j);
  end

  assign mode_o       = mode_q;
  assign valid_o      = valid_q;
  assign colour_out_o = res_q;
endmodule

>>> rtl/pcc_ctrl.sv
// Controller of the palette colour cycler: sequences each command over
// the datapath. Depends on pcc_pkg.
`timescale 1ns / 1ps
module pcc_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  output logic           busy_o,
  input  logic [2:0]     mode_i,
  input  pcc_pkg::stat_t stat_i,
  output pcc_pkg::ctrl_t ctrl_o
);
  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_FRAME, S_RD, S_WR, S_SH_HOLD, S_SH_RD, S_SH_WR, S_SH_TAIL
  } state_e;

  state_e state_q;
  logic [4:0] cnt_q;

  always_comb begin
    ctrl_o = '0;
    ctrl_o.latch = (state_q == S_IDLE) && start_i;
    case (state_q)
      S_DECODE: begin
        ctrl_o.load   = (mode_i == pcc_pkg::MODE_LOAD);
        ctrl_o.lookup = (mode_i == pcc_pkg::MODE_LOOKUP);
      end
      S_FRAME:   ctrl_o.frame_step = 1'b1;
      S_RD:      begin ctrl_o.rd_src_a = 1'b1; ctrl_o.rd_src_b = 1'b1; end
      S_WR:      begin ctrl_o.wr_work = 1'b1; ctrl_o.adv = 1'b1; end
      S_SH_HOLD: ctrl_o.hold_first = 1'b1;
      S_SH_RD:   ctrl_o.rd_work = 1'b1;
      S_SH_WR:   begin ctrl_o.wr_work = 1'b1; ctrl_o.adv = 1'b1; end
      S_SH_TAIL: ctrl_o.wr_tail = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: if (start_i) state_q <= S_DECODE;
        S_DECODE: begin
          cnt_q <= '0;
          if ((mode_i == pcc_pkg::MODE_ROTATE || mode_i == pcc_pkg::MODE_BLEND)
              && stat_i.range_ok)
            state_q <= S_FRAME;
          else if ((mode_i == pcc_pkg::MODE_SHIFT_R || mode_i == pcc_pkg::MODE_SHIFT_L)
              && stat_i.range_ok)
            state_q <= S_SH_HOLD;
          else
            state_q <= S_IDLE;
        end
        S_FRAME: begin
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == 5'(pcc_pkg::FRAME_STEPS - 1)) state_q <= S_RD;
        end
        S_RD: state_q <= S_WR;
        S_WR: state_q <= stat_i.last ? S_IDLE : S_RD;
        S_SH_HOLD: state_q <= S_SH_RD;
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: state_q <= stat_i.last ? S_SH_TAIL : S_SH_RD;
        S_SH_TAIL: state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign busy_o = (state_q != S_IDLE);

  a_no_latch_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_o |-> !ctrl_o.latch) else $error("latch while busy");
  a_decode_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> state_q == S_DECODE) else $error("start lost");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_o.wr_work && ctrl_o.wr_tail)) else $error("double write");
endmodule

>>> rtl/palette_colour_cycler_unit.sv
// Top level of the palette colour cycler: controller plus datapath.
// Depends on pcc_pkg, pcc_ctrl, pcc_datapath.
`timescale 1ns / 1ps
// Palette colour cycler. A command is taken when start is high and busy
// low. A lookup result appears on colour_out_o with valid_o high for
// exactly one cycle, once the command is latched and the decode state has
// read the working palette, and must be taken then: there is no stall from the receiver.
// A rotate or blended rotate runs 16 steps of the cycle-count reduction,
// then reads both source positions and writes the working palette for each
// entry; a shift holds the first entry, moves each entry and writes the tail.
// Invalid ranges and unused modes finish with no result.
module palette_colour_cycler_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode_i,
  input  logic [7:0]  entry_index_i,
  input  logic [31:0] colour_in_i,
  input  logic [7:0]  range_low_i,
  input  logic [7:0]  range_high_i,
  input  logic [15:0] cycle_count_i,
  input  logic [7:0]  blend_fraction_i,
  output logic        valid_o,
  output logic [31:0] colour_out_o
);
  pcc_pkg::ctrl_t ctrl;
  pcc_pkg::stat_t stat;
  logic [2:0] mode_q;

  pcc_ctrl u_ctrl (
    .clk_i, .rst_ni, .start_i(start), .busy_o(busy),
    .mode_i(mode_q), .stat_i(stat), .ctrl_o(ctrl)
  );

  pcc_datapath #(.PALETTE_ENTRIES(PALETTE_ENTRIES)) u_dp (
    .clk_i, .rst_ni, .ctrl_i(ctrl), .stat_o(stat),
    .mode_i, .entry_index_i, .colour_in_i, .range_low_i, .range_high_i,
    .cycle_count_i, .blend_fraction_i, .mode_o(mode_q),
    .valid_o, .colour_out_o
  );
endmodule
